// ===== rtl/tam_pkg.sv =====
`timescale 1ns / 1ps

package tam_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEPTH      = 2'd1;

    // Register reset values
    localparam logic [31:0] PHASE_STEP_RESET = 32'd4096;
    localparam logic [15:0] DEPTH_RESET      = 16'd32768;

    // Unity gain offset (0.5 in Q.33) and pi in Q30 for the table build
    localparam logic [32:0] GAIN_HALF = 33'h1_0000_0000;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // item accepted: latch sample, phase, table address
        logic rom_rd;    // read sine table
        logic gain_en;   // form gain from depth and sine
        logic prod_en;   // multiply magnitude by gain
        logic out_load;  // round, saturate and load output register
    } t_dp_cmd;

endpackage

// ===== rtl/tam_sine_rom.sv =====
`timescale 1ns / 1ps

module tam_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_addr,
    output logic [15:0]                         o_data
);

    localparam logic [63:0] ROM_DIV = 64'(4 * SINE_TABLE_DEPTH);

    // Quarter-wave midpoint sine, Q0.16, seven Taylor terms in Q30
    function automatic logic [15:0] rom_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (64'(2 * i + 1) * tam_pkg::PI_Q30) / ROM_DIV;
        x2 = (x * x) >> 30;
        s  = x;
        t  = ((x * x2) >> 30) / 6;
        s  = s - t;
        t  = ((t * x2) >> 30) / 20;
        s  = s + t;
        t  = ((t * x2) >> 30) / 42;
        s  = s - t;
        t  = ((t * x2) >> 30) / 72;
        s  = s + t;
        t  = ((t * x2) >> 30) / 110;
        s  = s - t;
        t  = ((t * x2) >> 30) / 156;
        s  = s + t;
        v  = (s * 64'd65535 + (64'd1 << 29)) >> 30;
        if (v > 64'd65535) begin
            v = 64'd65535;
        end
        return v[15:0];
    endfunction

    logic [15:0] w_rom [SINE_TABLE_DEPTH];

    // Constant table contents
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [15:0] ENTRY = rom_entry(g);
        assign w_rom[g] = ENTRY;
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= w_rom[i_addr];
        end
    end

endmodule

// ===== rtl/tam_datapath.sv =====
`timescale 1ns / 1ps

module tam_datapath #(
    parameter int unsigned SINE_TABLE_DEPTH = 256,
    parameter int unsigned SAMPLE_BITS      = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tam_pkg::t_dp_cmd                     i_cmd,
    input  logic                                 i_cfg_wr,
    input  logic [tam_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [tam_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    input  logic                                 i_buffer_start,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out
);

    localparam int unsigned IDX_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned SCALE_BITS = 31 + IDX_BITS;
    localparam int unsigned PROD_BITS  = SAMPLE_BITS + 33;
    localparam int unsigned RES_BITS   = SAMPLE_BITS + 1;

    logic [31:0]             r_phase_step;
    logic [15:0]             r_depth;
    logic [31:0]             r_phase_acc;
    logic [IDX_BITS-1:0]     r_addr;
    logic                    r_gain_neg;
    logic [SAMPLE_BITS-1:0]  r_mag;
    logic                    r_neg;
    logic [32:0]             r_gain;
    logic [PROD_BITS-1:0]    r_prod;
    logic [SAMPLE_BITS-1:0]  r_sample_out;

    logic [31:0]             w_phase;
    logic [SCALE_BITS-1:0]   w_scaled;
    logic [IDX_BITS-1:0]     w_idx;
    logic [IDX_BITS-1:0]     w_addr;
    logic [SAMPLE_BITS-1:0]  w_raw;
    logic                    w_neg;
    logic [SAMPLE_BITS-1:0]  w_mag;
    logic [15:0]             w_sine;
    logic [31:0]             w_dm;
    logic [32:0]             w_gain;
    logic [PROD_BITS:0]      w_rnd;
    logic [RES_BITS-1:0]     w_r;
    logic [RES_BITS-1:0]     w_lim;
    logic [RES_BITS-1:0]     w_sat;
    logic [SAMPLE_BITS-1:0]  w_out;

    // Phase for this item and its table address (mirror in odd quadrants)
    assign w_phase  = i_buffer_start ? 32'd0 : r_phase_acc;
    assign w_scaled = SCALE_BITS'(w_phase[29:0]) * SCALE_BITS'(SINE_TABLE_DEPTH);
    assign w_idx    = w_scaled[29+IDX_BITS:30];
    assign w_addr   = w_phase[30] ? (IDX_BITS'(SINE_TABLE_DEPTH - 1) - w_idx) : w_idx;

    // Sign and magnitude of the sample
    assign w_raw = i_sample_in;
    assign w_neg = w_raw[SAMPLE_BITS-1];
    assign w_mag = w_neg ? (~w_raw + 1'b1) : w_raw;

    tam_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (i_cmd.rom_rd),
        .i_addr(r_addr),
        .o_data(w_sine)
    );

    // Gain = 0.5 +/- depth * sine / 2
    assign w_dm   = 32'(r_depth) * 32'(w_sine);
    assign w_gain = r_gain_neg ? (tam_pkg::GAIN_HALF - {1'b0, w_dm})
                               : (tam_pkg::GAIN_HALF + {1'b0, w_dm});

    // Round half away from zero, saturate, restore sign
    assign w_rnd = {1'b0, r_prod} + (PROD_BITS + 1)'(tam_pkg::GAIN_HALF);
    assign w_r   = w_rnd[PROD_BITS:33];
    assign w_lim = r_neg ? {2'b01, {(SAMPLE_BITS-1){1'b0}}}
                         : {2'b00, {(SAMPLE_BITS-1){1'b1}}};
    assign w_sat = (w_r > w_lim) ? w_lim : w_r;
    assign w_out = r_neg ? (~w_sat[SAMPLE_BITS-1:0] + 1'b1) : w_sat[SAMPLE_BITS-1:0];

    // Configuration registers and phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= tam_pkg::PHASE_STEP_RESET;
            r_depth      <= tam_pkg::DEPTH_RESET;
            r_phase_acc  <= 32'd0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    tam_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                    tam_pkg::CFG_DEPTH:      r_depth      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_in) begin
                r_phase_acc <= w_phase + r_phase_step;
            end
        end
    end

    // Payload pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_addr     <= w_addr;
            r_gain_neg <= w_phase[31];
            r_mag      <= w_mag;
            r_neg      <= w_neg;
        end
        if (i_cmd.gain_en) begin
            r_gain <= w_gain;
        end
        if (i_cmd.prod_en) begin
            r_prod <= PROD_BITS'(r_mag) * PROD_BITS'(r_gain);
        end
        if (i_cmd.out_load) begin
            r_sample_out <= w_out;
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

// ===== rtl/tam_ctrl.sv =====
`timescale 1ns / 1ps

module tam_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output tam_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROM  = 3'd1;
    localparam logic [2:0] S_GAIN = 3'd2;
    localparam logic [2:0] S_PROD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // Output register is free when empty or being taken this cycle
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_ROM;
            S_ROM:   n_state = S_GAIN;
            S_GAIN:  n_state = S_PROD;
            S_PROD:  n_state = S_OUT;
            S_OUT:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath commands
    assign o_cmd.load_in  = w_accept;
    assign o_cmd.rom_rd   = (r_state == S_ROM);
    assign o_cmd.gain_en  = (r_state == S_GAIN);
    assign o_cmd.prod_en  = (r_state == S_PROD);
    assign o_cmd.out_load = w_load;

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/tremolo_amplitude_modulator.sv =====
// Each item goes through the controller sequence of accept, sine table read, gain
// multiply, sample multiply and output load; the output load waits while a held
// result is not taken, and a new item is accepted only after that load.
// The output register lets the next item in while a result waits to be taken.
// Reset (synchronous, active low) clears the phase and control, and loads the
// register defaults (phase step 4096, depth 32768).
`timescale 1ns / 1ps

module tremolo_amplitude_modulator #(
    parameter int unsigned SINE_TABLE_DEPTH = 256,
    parameter int unsigned SAMPLE_BITS      = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    input  logic                               i_buffer_start,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tam_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [tam_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    tam_pkg::t_dp_cmd w_cmd;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    tam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_ready(i_out_ready),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (w_cmd)
    );

    tam_datapath #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_wr      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample_in   (i_sample_in),
        .i_buffer_start(i_buffer_start),
        .o_sample_out  (o_sample_out)
    );

endmodule

// ===== rtl/tam_checker.sv =====
`timescale 1ns / 1ps

module tam_checker #(
    parameter int unsigned SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_sample_out
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("result changed or dropped while stalled");

    // One item at a time: no new item while the accepted one is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=>
            !o_in_ready ##1 !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("item accepted while the previous one is in flight");

    // An item accepted while the output is empty comes out valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> ##4 o_out_valid)
        else $error("result missing after fixed latency");

    // A result only rises after an accepted item
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 5))
        else $error("result without a matching item");

endmodule

bind tremolo_amplitude_modulator tam_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_tam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_sample_out(o_sample_out)
);
